/* hdl/lennard_jones_pair_force_energy_defines.svh */
// Assertion macros for the Lennard-Jones pair force and energy block.
`ifndef LENNARD_JONES_PAIR_FORCE_ENERGY_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_ENERGY_DEFINES_SVH
`ifndef SYNTH
`define LJPF_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LJPF_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LJPF_CHECK(label, ante, cons, msg)
`define LJPF_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/ljpf_pkg.sv */
// Shared constants and types for the Lennard-Jones pair force and energy block.
`default_nettype none
package ljpf_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 24;
	localparam int FIELD_WIDTH = 32;
	localparam int UWIDTH = 64;
	localparam int OUT_WIDTH = 48;

	typedef enum logic [1:0] {
		REG_SIGMA = 2'd0,
		REG_EPSILON = 2'd1,
		REG_R_MIN = 2'd2
	} reg_idx_t;
endpackage
`default_nettype wire

/* hdl/ljpf_mulq.sv */
// Three-stage saturating 64x64 fixed-point multiplier with a sideband carried alongside.
`default_nettype none
module ljpf_mulq #(
	parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF,
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [ljpf_pkg::UWIDTH-1:0] a,
	input  logic [ljpf_pkg::UWIDTH-1:0] b,
	input  logic [SW-1:0]               side_in,
	output logic                        out_vld,
	output logic [ljpf_pkg::UWIDTH-1:0] p,
	output logic [SW-1:0]               side_out
);
	logic        vld_s1, vld_s2, vld_s3;
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [SW-1:0] side_s1, side_s2, side_s3;
	logic [33:0] mid_s2;
	logic [63:0] hi_s2;
	logic [31:0] lo_s2;
	logic [63:0] p_s3;

	logic [63:0] p00, p01, p10, p11;
	logic [33:0] mid;
	logic [63:0] hi_part;
	logic [63:0] hi;
	logic [127:0] prod;
	logic [63:0] res;

	assign p00 = a[31:0] * b[31:0];
	assign p01 = a[31:0] * b[63:32];
	assign p10 = a[63:32] * b[31:0];
	assign p11 = a[63:32] * b[63:32];

	assign mid = {2'b00, p00_s1[63:32]} + {2'b00, p01_s1[31:0]} + {2'b00, p10_s1[31:0]};
	assign hi_part = p11_s1 + {32'd0, p01_s1[63:32]} + {32'd0, p10_s1[63:32]};

	assign hi = hi_s2 + {62'd0, mid_s2[33:32]};
	assign prod = {hi, mid_s2[31:0], lo_s2};
	// anything at or above bit 64 of the scaled result saturates
	assign res = ((hi >> FRAC_BITS) != 64'd0) ? '1 : prod[FRAC_BITS+63:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= p00;
			p01_s1  <= p01;
			p10_s1  <= p10;
			p11_s1  <= p11;
			side_s1 <= side_in;
			mid_s2  <= mid;
			hi_s2   <= hi_part;
			lo_s2   <= p00_s1[31:0];
			side_s2 <= side_s1;
			p_s3    <= res;
			side_s3 <= side_s2;
		end
	end

	assign out_vld = vld_s3;
	assign p = p_s3;
	assign side_out = side_s3;
endmodule
`default_nettype wire

/* hdl/lennard_jones_pair_force_energy.sv */
// The pipeline is set by the one-bit-per-stage divider for sigma/r and six three-stage
// multipliers in series, with input, quotient, offset and output registers around them.
// Throughput: one pair distance per cycle; a held result stalls the whole pipe.
// Reset clears all valid bits and loads sigma = 1.0, epsilon = 1.0, r_min = 0.75.
`default_nettype none
module lennard_jones_pair_force_energy #(
	parameter int DATA_WIDTH = ljpf_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] r
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // [47:0] pair_energy, [95:48] pair_force
);
	`include "lennard_jones_pair_force_energy_defines.svh"

	localparam int VW = (DATA_WIDTH < ljpf_pkg::FIELD_WIDTH) ? DATA_WIDTH
		: ljpf_pkg::FIELD_WIDTH;
	localparam int QW = VW + FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic [63:0] RMIN_RST = 64'd3 << (FRAC_BITS - 2);
	localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MIN = 48'h8000_0000_0000;
	localparam logic [63:0] FORCE_LIM = 64'd5864062014805;  // floor(2^47 / 24)

	logic [VW-1:0] sigma_q, eps_q, rmin_q;
	logic en;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= ONE[VW-1:0];
			eps_q   <= ONE[VW-1:0];
			rmin_q  <= RMIN_RST[VW-1:0];
		end else if (cfg_we) begin
			case (cfg_addr)
				ljpf_pkg::REG_SIGMA:   sigma_q <= cfg_wdata[VW-1:0];
				ljpf_pkg::REG_EPSILON: eps_q   <= cfg_wdata[VW-1:0];
				ljpf_pkg::REG_R_MIN:   rmin_q  <= cfg_wdata[VW-1:0];
				default: ;
			endcase
		end
	end

	// input stage: clamp r up to r_min
	logic          vld_s0;
	logic [VW-1:0] r_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (en) vld_s0 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) r_s0 <= (s_tdata[VW-1:0] <= rmin_q) ? rmin_q : s_tdata[VW-1:0];
	end

	// restoring divider, one quotient bit per stage: sigma * 2^F / r
	logic [VW-1:0] dv_rem_s [QW-1];
	logic [VW-1:0] dv_den_s [QW];
	logic [QW-1:0] dv_quo_s [QW];
	logic          dv_vld_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [VW-1:0] prev_rem, prev_den;
		logic [QW-1:0] prev_quo;
		logic          prev_vld, nbit, ge;
		logic [VW:0]   trial, diff;

		if (k == 0) begin : g_first
			assign prev_rem = '0;
			assign prev_den = r_s0;
			assign prev_quo = '0;
			assign prev_vld = vld_s0;
		end else begin : g_next
			assign prev_rem = dv_rem_s[k-1];
			assign prev_den = dv_den_s[k-1];
			assign prev_quo = dv_quo_s[k-1];
			assign prev_vld = dv_vld_s[k-1];
		end

		if (k < VW) begin : g_num
			assign nbit = sigma_q[VW-1-k];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign trial = {prev_rem, nbit};
		assign diff = trial - {1'b0, prev_den};
		assign ge = trial >= {1'b0, prev_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k] <= 1'b0;
			else if (en) dv_vld_s[k] <= prev_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[k] <= prev_den;
				dv_quo_s[k] <= {prev_quo[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) dv_rem_s[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
			end
		end
	end

	// quotient to saturating 64-bit q
	logic [63:0] q_full;
	logic        q_over;

	if (QW > 64) begin : g_qwide
		assign q_full = dv_quo_s[QW-1][63:0];
		assign q_over = |dv_quo_s[QW-1][QW-1:64];
	end else begin : g_qnarrow
		assign q_full = 64'(dv_quo_s[QW-1]);
		assign q_over = 1'b0;
	end

	logic        vld_s1;
	logic [63:0] q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= dv_vld_s[QW-1];
	end

	always_ff @(posedge clk) begin
		if (en) q_s1 <= (q_over || dv_den_s[QW-1] == '0) ? '1 : q_full;
	end

	// ir2 = q*q, ir4 = ir2*ir2, ir6 = ir4*ir2
	logic         m1_vld, m2_vld, m3_vld;
	logic [63:0]  m1_p, m2_p, m3_p;
	logic [63:0]  m1_side, m3_side;
	logic [127:0] m2_side;

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(64)) u_mul_ir2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1),
		.a(q_s1), .b(q_s1), .side_in(q_s1),
		.out_vld(m1_vld), .p(m1_p), .side_out(m1_side)
	);

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(128)) u_mul_ir4 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(m1_vld),
		.a(m1_p), .b(m1_p), .side_in({m1_side, m1_p}),
		.out_vld(m2_vld), .p(m2_p), .side_out(m2_side)
	);

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(64)) u_mul_ir6 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(m2_vld),
		.a(m2_p), .b(m2_side[63:0]), .side_in(m2_side[127:64]),
		.out_vld(m3_vld), .p(m3_p), .side_out(m3_side)
	);

	// distance of ir6 and 2*ir6 from one, with signs
	logic [63:0] two6;
	logic        eneg, fneg;

	assign two6 = m3_p[63] ? '1 : {m3_p[62:0], 1'b0};
	assign eneg = m3_p < ONE;
	assign fneg = two6 < ONE;

	logic        vld_s2, eneg_s2, fneg_s2;
	logic [63:0] ir6_s2, de_s2, df_s2, q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= m3_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ir6_s2  <= m3_p;
			eneg_s2 <= eneg;
			fneg_s2 <= fneg;
			de_s2   <= eneg ? ONE - m3_p : m3_p - ONE;
			df_s2   <= fneg ? ONE - two6 : two6 - ONE;
			q_s2    <= m3_side;
		end
	end

	// e6 = eps*ir6, then e6*de and e6*df in parallel, then (e6*df)*q
	logic         m4_vld, m5_vld, m6_vld, m7_vld;
	logic [63:0]  m4_p, m5_p, m6_p, m7_p;
	logic [193:0] m4_side;
	logic [1:0]   m5_side;
	logic [63:0]  m6_side;
	logic [65:0]  m7_side;

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(194)) u_mul_e6 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s2),
		.a(64'(eps_q)), .b(ir6_s2),
		.side_in({q_s2, de_s2, df_s2, eneg_s2, fneg_s2}),
		.out_vld(m4_vld), .p(m4_p), .side_out(m4_side)
	);

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(2)) u_mul_energy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(m4_vld),
		.a(m4_p), .b(m4_side[129:66]), .side_in(m4_side[1:0]),
		.out_vld(m5_vld), .p(m5_p), .side_out(m5_side)
	);

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(64)) u_mul_force (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(m4_vld),
		.a(m4_p), .b(m4_side[65:2]), .side_in(m4_side[193:130]),
		.out_vld(m6_vld), .p(m6_p), .side_out(m6_side)
	);

	ljpf_mulq #(.FRAC_BITS(FRAC_BITS), .SW(66)) u_mul_force_q (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(m5_vld && m6_vld),
		.a(m6_p), .b(m6_side), .side_in({m5_p, m5_side}),
		.out_vld(m7_vld), .p(m7_p), .side_out(m7_side)
	);

	// scale by 4 and 24, apply sign, saturate to 48 bits
	logic [63:0] em, fm;
	logic        eneg_o, fneg_o;
	logic [47:0] e4, f24, energy_n, force_n;

	assign em = m7_side[65:2];
	assign eneg_o = m7_side[1];
	assign fneg_o = m7_side[0];
	assign fm = m7_p;
	assign e4 = {em[45:0], 2'b00};
	assign f24 = {fm[43:0], 4'b0000} + {fm[44:0], 3'b000};

	always_comb begin
		if (!eneg_o) energy_n = (em[63:45] != '0) ? POS_MAX : e4;
		else energy_n = (em > (64'd1 << 45)) ? NEG_MIN : (48'd0 - e4);
		if (fm > FORCE_LIM) force_n = fneg_o ? NEG_MIN : POS_MAX;
		else force_n = fneg_o ? (48'd0 - f24) : f24;
	end

	logic        vld_s3;
	logic [47:0] energy_s3, force_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= m7_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			energy_s3 <= energy_n;
			force_s3  <= force_n;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata = {force_s3, energy_s3};

	`LJPF_CHECK(a_force_sign_implies_energy_sign, vld_s2 && fneg_s2, eneg_s2,
		"force negative with ir6 >= 1")
	`LJPF_CHECK(a_out_force_neg_energy_nonpos, m_tvalid && m_tdata[95],
		m_tdata[47] || (m_tdata[47:0] == 48'd0), "negative force with positive energy")
	`LJPF_CHECK_NEXT(a_stall_keeps_result, !s_tready, m_tvalid, "result lost during stall")
endmodule
`default_nettype wire

/* tb/lennard_jones_pair_force_energy_test.sv */
// Stream testbench for the Lennard-Jones pair force and energy block.
`default_nettype none
module lennard_jones_pair_force_energy_test;
	localparam int FB = 24;
	localparam logic [63:0] UMAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [31:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;

	lennard_jones_pair_force_energy DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor copy of the registers
	logic [31:0] lj_sigma, lj_eps, lj_rmin;

	logic [31:0] pending_r[$];
	logic [95:0] expected_pairs[$];
	int errors, n_sent, n_checked, n_clamped;
	bit hold_sender;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		if (p[127:64+FB] != 0)
			return UMAX;
		return p[63+FB:FB];
	endfunction

	function automatic logic [63:0] mul_k(logic [63:0] x, logic [63:0] k);
		logic [127:0] p;
		p = x * k;
		if (p[127:64] != 0)
			return UMAX;
		return p[63:0];
	endfunction

	function automatic logic [47:0] to_out(logic [63:0] mag, bit neg);
		if (!neg)
			return mag > {16'h0, POS_MAX} ? POS_MAX : mag[47:0];
		if (mag > NEG_MAG)
			mag = NEG_MAG;
		return 48'(64'h0 - mag);
	endfunction

	function automatic logic [95:0] lj_pair(logic [31:0] r_in);
		logic [63:0] r, q, ir2, ir4, ir6, e6, d, two6, emag, fmag, one;
		logic [127:0] num;
		bit eneg, fneg;
		one = 64'd1 << FB;
		r = (r_in <= lj_rmin) ? lj_rmin : r_in;
		num = {64'h0, lj_sigma} << FB;
		if (r == 0)
			q = UMAX;
		else begin
			num = num / r;
			q = (num[127:64] != 0) ? UMAX : num[63:0];
		end
		ir2 = mul_q(q, q);
		ir4 = mul_q(ir2, ir2);
		ir6 = mul_q(ir4, ir2);
		e6 = mul_q({32'h0, lj_eps}, ir6);
		eneg = ir6 < one;
		d = eneg ? one - ir6 : ir6 - one;
		emag = mul_k(mul_q(e6, d), 4);
		two6 = mul_k(ir6, 2);
		fneg = two6 < one;
		d = fneg ? one - two6 : two6 - one;
		fmag = mul_k(mul_q(mul_q(e6, d), q), 24);
		return {to_out(fmag, fneg), to_out(emag, eneg)};
	endfunction

	task automatic report(string what, logic [47:0] got, logic [47:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// driver
	int s_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= 0;
			s_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_pairs.push_back(lj_pair(s_tdata));
				n_sent++;
				if (s_tdata <= lj_rmin)
					n_clamped++;
			end
			if (!s_tvalid || s_tready) begin
				if (s_gap > 0) begin
					s_gap <= s_gap - 1;
					s_tvalid <= 0;
				end else if (pending_r.size() > 0 && !hold_sender) begin
					s_tvalid <= 1;
					s_tdata <= pending_r.pop_front();
					s_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				end else
					s_tvalid <= 0;
			end
		end
	end

	// monitor
	int m_gap;
	int m_draw;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			m_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pairs.size() == 0) begin
					report("unexpected result", m_tdata[47:0], 48'd0);
				end else begin
					logic [95:0] want;
					want = expected_pairs.pop_front();
					if (m_tdata[47:0] !== want[47:0])
						report("pair_energy", m_tdata[47:0], want[47:0]);
					if (m_tdata[95:48] !== want[95:48])
						report("pair_force", m_tdata[95:48], want[95:48]);
				end
				n_checked++;
				m_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				m_gap <= m_draw;
				m_tready <= (m_draw == 0);
			end else if (m_gap > 0) begin
				m_gap <= m_gap - 1;
				m_tready <= 0;
			end else
				m_tready <= 1;
		end
	end

	task automatic write_reg(ljpf_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			ljpf_pkg::REG_SIGMA: lj_sigma = val;
			ljpf_pkg::REG_EPSILON: lj_eps = val;
			default: lj_rmin = val;
		endcase
	endtask

	task automatic drain();
		while (pending_r.size() > 0 || s_tvalid || expected_pairs.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// distances biased toward the interesting range around sigma
	function automatic logic [31:0] rand_r();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0100_0000);
			2: return lj_rmin + $urandom_range(0, 3) - 1;
			default: return lj_sigma / 2 + $urandom_range(0, 32'h0300_0000);
		endcase
	endfunction

	initial begin
		logic [31:0] sig_set[6];
		logic [31:0] eps_set[6];
		logic [31:0] rmin_set[6];
		sig_set = '{32'h0100_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0080_0000, 32'h0200_0000, 32'h0133_3333};
		eps_set = '{32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0040_0000, 32'h0001_0000, 32'h0A00_0000};
		rmin_set = '{32'h00C0_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0000_0000, 32'h0080_0000, 32'h00E0_0000};
		errors = 0; n_sent = 0; n_checked = 0; n_clamped = 0;
		hold_sender = 0;
		lj_sigma = 32'h0100_0000;
		lj_eps = 32'h0100_0000;
		lj_rmin = 32'h00C0_0000;
		arst_n = 0;
		cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: reset settings
		pending_r.push_back(32'h0);
		pending_r.push_back(32'hFFFF_FFFF);
		pending_r.push_back(32'h00C0_0000);
		pending_r.push_back(32'h00C0_0001);
		pending_r.push_back(32'h00BF_FFFF);
		pending_r.push_back(32'h0100_0000);
		pending_r.push_back(32'h011F_5FFF);
		pending_r.push_back(32'h0200_0000);
		pending_r.push_back(32'h0000_0001);
		for (int b = 0; b < 32; b += 4)
			pending_r.push_back(32'h1 << b | 32'h5555_5555 >> b);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(ljpf_pkg::REG_SIGMA, sig_set[ph]);
			write_reg(ljpf_pkg::REG_EPSILON, eps_set[ph]);
			write_reg(ljpf_pkg::REG_R_MIN, rmin_set[ph]);
			pending_r.push_back(32'h0);
			pending_r.push_back(32'hFFFF_FFFF);
			for (int i = 0; i < 275; i++) begin
				pending_r.push_back(rand_r());
				if (i == 140) begin
					// sender holds until the pipe is empty
					while (pending_r.size() > 0 || s_tvalid) @(posedge clk);
					hold_sender = 1;
					while (expected_pairs.size() > 0) @(posedge clk);
					hold_sender = 0;
				end
			end
			drain();
		end
		$display("%0d distances sent, %0d results checked, %0d clamped at r_min",
			n_sent, n_checked, n_clamped);
		$display("six register settings incl. zero r_min, unit and full-scale values");
		if (errors == 0)
			$display("lennard_jones_pair_force_energy_test OK");
		else
			$display("lennard_jones_pair_force_energy_test NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("lennard_jones_pair_force_energy_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
